[src/ptia_pkg.sv]
package ptia_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned KEY_W     = ADDR_W + PORT_W;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned MASK_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;
  localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 8'd30;

  typedef enum logic [1:0] {
    OUT_FOUND = 2'd0,
    OUT_ADDED = 2'd1,
    OUT_FULL  = 2'd2,
    OUT_TICK  = 2'd3
  } outcome_e;

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] peer_address;
    logic [PORT_W-1:0] peer_port;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [1:0]        outcome;
    logic [MASK_W-1:0] expired_mask;
  } rsp_t;

endpackage

[src/ptia_ram.sv]
module ptia_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/peer_table_with_idle_aging.sv]
// Peer table with idle aging.
//
// Input channel (in_valid_i / in_stall_o, payload in_data_i) carries packet
// and tick transactions; the output channel (out_valid_o / out_stall_i,
// payload out_data_o) returns exactly one result per input transaction.
// The idle timeout register is written through cfg_valid_i / cfg_ready_o /
// cfg_data_i, only while the block is idle.
//
// A packet walks the slots one per cycle through a single key comparator
// fed by the address/port RAM: the accept, a read lead-in, then compares
// over the slots, fewer on an early hit, and the load of the result.
// A tick updates one idle counter per cycle through a shared
// increment/compare unit and then loads its result.
// in_stall_o is high while a transaction is in work.
//
// Reset clears all valid marks and idle counters and sets the timeout to 30.
// If the receiver stalls, the finished result holds in the output register;
// the block still takes the next input, and only stalls the one after that
// until the output register drains.
module peer_table_with_idle_aging #(
  parameter int unsigned SLOTS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ptia_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ptia_pkg::rsp_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_data_i
);

  import ptia_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PKT,
    ST_TICK,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] timeout_q;
  logic               slot_valid_q [SLOTS];
  logic [COUNT_W-1:0] idle_count_q [SLOTS];

  logic [ADDR_W-1:0]  addr_q;
  logic [PORT_W-1:0]  port_q;

  logic [IW-1:0]      rd_idx_q;
  logic               rd_more_q;
  logic [IW-1:0]      cmp_idx_q;
  logic               cmp_vld_q;
  logic               free_found_q;
  logic [IW-1:0]      free_idx_q;

  logic [IW-1:0]      tk_idx_q;
  logic [MASK_W-1:0]  mask_q;

  rsp_t               res_q;
  rsp_t               out_q;
  logic               out_valid_q;

  logic [KEY_W-1:0]   ram_rdata;
  logic               cur_valid;
  logic               match;
  logic               last_cmp;
  logic               free_any;
  logic [IW-1:0]      free_sel;
  logic               ram_we;
  logic               out_load;

  logic [COUNT_W-1:0] tk_cnt;
  logic [COUNT_W-1:0] tk_inc;
  logic               tk_expire;
  logic               tk_reported;
  logic [SLOT_W-1:0]  tk_slot;

  assign cur_valid = slot_valid_q[cmp_idx_q];
  assign match     = cmp_vld_q && cur_valid && (ram_rdata == {addr_q, port_q});
  assign last_cmp  = cmp_vld_q && (cmp_idx_q == LAST);
  assign free_any  = free_found_q || !cur_valid;
  assign free_sel  = free_found_q ? free_idx_q : cmp_idx_q;
  assign ram_we    = (state_q == ST_PKT) && !match && last_cmp && free_any;
  assign out_load  = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // Shared aging unit: saturating increment, then timeout compare.
  assign tk_cnt      = idle_count_q[tk_idx_q];
  assign tk_inc      = (tk_cnt == COUNT_MAX) ? tk_cnt : tk_cnt + 8'd1;
  assign tk_expire   = slot_valid_q[tk_idx_q] && (tk_inc > timeout_q);
  assign tk_reported = (32'(tk_idx_q) < 32'(MASK_W));
  assign tk_slot     = SLOT_W'(tk_idx_q);

  ptia_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_sel),
    .wdata_i ({addr_q, port_q}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid_q[i] <= 1'b0;
        idle_count_q[i] <= '0;
      end
      addr_q       <= '0;
      port_q       <= '0;
      rd_idx_q     <= '0;
      rd_more_q    <= 1'b0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      tk_idx_q     <= '0;
      mask_q       <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            addr_q       <= in_data_i.peer_address;
            port_q       <= in_data_i.peer_port;
            rd_idx_q     <= '0;
            rd_more_q    <= 1'b1;
            cmp_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            tk_idx_q     <= '0;
            mask_q       <= '0;
            state_q      <= (in_data_i.req_type == REQ_TICK) ? ST_TICK : ST_PKT;
          end
        end

        ST_PKT: begin
          // read slot rd_idx while comparing the key read the cycle before
          cmp_vld_q <= rd_more_q;
          cmp_idx_q <= rd_idx_q;
          if (rd_more_q) begin
            if (rd_idx_q == LAST) begin
              rd_more_q <= 1'b0;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end
          if (cmp_vld_q && !cur_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
          if (match) begin
            idle_count_q[cmp_idx_q] <= '0;
            res_q   <= '{slot_index: SLOT_W'(cmp_idx_q), outcome: OUT_FOUND,
                         expired_mask: '0};
            state_q <= ST_RESP;
          end else if (last_cmp) begin
            if (free_any) begin
              slot_valid_q[free_sel] <= 1'b1;
              idle_count_q[free_sel] <= '0;
              res_q <= '{slot_index: SLOT_W'(free_sel), outcome: OUT_ADDED,
                         expired_mask: '0};
            end else begin
              res_q <= '{slot_index: '0, outcome: OUT_FULL, expired_mask: '0};
            end
            state_q <= ST_RESP;
          end
        end

        ST_TICK: begin
          idle_count_q[tk_idx_q] <= tk_inc;
          if (tk_expire) begin
            slot_valid_q[tk_idx_q] <= 1'b0;
          end
          if (tk_expire && tk_reported) begin
            mask_q[tk_slot] <= 1'b1;
          end
          if (tk_idx_q == LAST) begin
            res_q <= '{slot_index: '0, outcome: OUT_TICK,
                       expired_mask: mask_q | ((tk_expire && tk_reported) ?
                                               (MASK_W'(1) << tk_slot) : '0)};
            state_q <= ST_RESP;
          end else begin
            tk_idx_q <= tk_idx_q + 1'b1;
          end
        end

        ST_RESP: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule

[tb/peer_table_checker.sv]
module peer_table_checker
  import ptia_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  req_t       in_data_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  rsp_t       out_data_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  // shadow copy of the peer table
  logic                live  [SLOTS];
  logic [ADDR_W-1:0]   addr  [SLOTS];
  logic [PORT_W-1:0]   port  [SLOTS];
  logic [COUNT_W-1:0]  idle  [SLOTS];
  logic [COUNT_W-1:0]  timeout;

  rsp_t result_q[$];
  rsp_t want;
  int   errors;

  assign fail_count_o = errors;

  function automatic rsp_t lookup_or_age(req_t r);
    rsp_t res;
    int   hit;
    int   free_slot;
    res = '0;
    if (r.req_type == REQ_TICK) begin
      res.outcome = OUT_TICK;
      for (int i = 0; i < SLOTS; i++) begin
        if (idle[i] != COUNT_MAX) idle[i] = idle[i] + 1'b1;
        if (live[i] && idle[i] > timeout) begin
          live[i] = 1'b0;
          if (i < MASK_W) res.expired_mask[i] = 1'b1;
        end
      end
    end else begin
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && live[i] && addr[i] == r.peer_address && port[i] == r.peer_port)
          hit = i;
        if (free_slot < 0 && !live[i]) free_slot = i;
      end
      if (hit >= 0) begin
        idle[hit] = '0;
        res.slot_index = hit[SLOT_W-1:0];
        res.outcome = OUT_FOUND;
      end else if (free_slot >= 0) begin
        live[free_slot] = 1'b1;
        addr[free_slot] = r.peer_address;
        port[free_slot] = r.peer_port;
        idle[free_slot] = '0;
        res.slot_index = free_slot[SLOT_W-1:0];
        res.outcome = OUT_ADDED;
      end else begin
        res.outcome = OUT_FULL;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
        addr[i] = '0;
        port[i] = '0;
        idle[i] = '0;
      end
      timeout = TIMEOUT_RESET;
      result_q.delete();
      errors = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) timeout = cfg_data_i;
      // retire the output transaction first: it can never belong to an input
      // accepted at the same edge
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: slot_index %0d outcome %0d expired_mask %0h",
                 out_data_o.slot_index, out_data_o.outcome, out_data_o.expired_mask);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_data_o.slot_index !== want.slot_index) begin
            $error("slot_index expected %0d got %0d", want.slot_index, out_data_o.slot_index);
            errors++;
          end
          if (out_data_o.outcome !== want.outcome) begin
            $error("outcome expected %0d got %0d", want.outcome, out_data_o.outcome);
            errors++;
          end
          if (out_data_o.expired_mask !== want.expired_mask) begin
            $error("expired_mask expected %0h got %0h", want.expired_mask,
                   out_data_o.expired_mask);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) result_q.push_back(lookup_or_age(in_data_i));
      pending_o <= result_q.size();
    end
  end

endmodule

[tb/tb_peer_table_with_idle_aging.sv]
module tb_peer_table_with_idle_aging;
  import ptia_pkg::*;

  localparam int unsigned SLOTS = 8;
  localparam int IDLE_PCT    = 36;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL        = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES      = 7;
  localparam int SETTLE      = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  req_t       in_data;
  logic       out_valid;
  logic       out_stall;
  rsp_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  int         fail_count;
  int         pending;

  bit quiet;
  bit hold_req;

  logic [ADDR_W-1:0] pool_addr [POOL];
  logic [PORT_W-1:0] pool_port [POOL];

  peer_table_with_idle_aging #(.SLOTS(SLOTS)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  peer_table_checker #(.SLOTS(SLOTS)) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_data_i    (in_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_o   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("[peer_table_with_idle_aging] ERROR");
    $finish;
  end

  // result side: random stall, quiet stretches, and one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic req_t peer_packet(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
    req_t r;
    r.req_type = REQ_PACKET;
    r.peer_address = a;
    r.peer_port = p;
    return r;
  endfunction

  function automatic req_t aging_tick();
    req_t r;
    r.req_type = REQ_TICK;
    r.peer_address = $urandom;
    r.peer_port = PORT_W'($urandom_range(0, 65535));
    return r;
  endfunction

  // peers that partly share address or port, more of them than slots
  task automatic refill_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_addr[i] = (i % 2 == 1) ? pool_addr[i-1] : $urandom;
      pool_port[i] = (i % 3 == 2) ? pool_port[i-1] : PORT_W'($urandom_range(0, 65535));
    end
  endtask

  function automatic req_t random_item(int tick_pct);
    int roll;
    int k;
    roll = $urandom_range(99);
    k = $urandom_range(POOL - 1);
    if (roll < tick_pct) return aging_tick();
    if (roll < 92) return peer_packet(pool_addr[k], pool_port[k]);
    return peer_packet($urandom, PORT_W'($urandom_range(0, 65535)));
  endfunction

  task automatic send_item(req_t r);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_timeout(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] timeouts [PHASES];
    int         tick_pct [PHASES];
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    timeouts = '{8'd1, 8'd0, 8'd3, 8'd30, 8'($urandom_range(4, 29)), 8'd255, 8'd254};
    tick_pct = '{30, 20, 30, 45, 35, 25, 25};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the table with field extremes, hit, overflow, then age at reset timeout
    send_item(peer_packet('0, '0));
    send_item(peer_packet('1, '1));
    send_item(peer_packet('0, '0));
    send_item(peer_packet('0, '1));
    send_item(peer_packet('1, '0));
    send_item(peer_packet(32'hA5A5_A5A5, 16'h5A5A));
    send_item(peer_packet(32'h5A5A_5A5A, 16'hA5A5));
    send_item(peer_packet(32'h1234_5678, 16'h1234));
    send_item(peer_packet(32'h8765_4321, 16'h4321));
    send_item(peer_packet(32'hDEAD_BEEF, 16'hBEEF));
    send_item(peer_packet('1, '1));
    send_item(aging_tick());
    send_item(peer_packet('0, '1));

    // zero timeout: everything live expires on the next tick
    drain();
    write_timeout(8'd0);
    send_item(aging_tick());
    send_item(aging_tick());
    send_item(peer_packet(32'hDEAD_BEEF, 16'hBEEF));
    send_item(aging_tick());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_timeout(timeouts[ph]);
      refill_pool();
      quiet = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      // counters saturated in the previous phase expire right away
      if (ph == 6) send_item(aging_tick());
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(tick_pct[ph]));
      // timeout 255: drive every counter into saturation without expiry
      if (ph == 5) repeat (256) send_item(aging_tick());
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("[peer_table_with_idle_aging] OK");
    else
      $display("[peer_table_with_idle_aging] ERROR");
    $finish;
  end

endmodule
